// ----- hdl/utq_pkg.sv -----
// shared types and codes for the uart transmitter with byte queue
package utq_pkg;

   // item function codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam int BYTE_W = 8;
   localparam int FILL_W = 5;

   // input word
   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] data_byte;
   } req_word_type;

   // result word
   typedef struct packed {
      logic              line_level;
      logic [FILL_W-1:0] queue_fill;
      logic              push_dropped;
   } rsp_word_type;

   // classified command from front to back
   typedef struct packed {
      logic              is_tick;
      logic [BYTE_W-1:0] data_byte;
   } cmd_type;

endpackage

// ----- hdl/utq_front.sv -----
// front end: accepts input words, classifies them and queues commands
module utq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  utq_pkg::req_word_type req_word,
   output logic                 cmd_valid,
   output utq_pkg::cmd_type     cmd,
   input  logic                 cmd_pop
);
   import utq_pkg::*;

   localparam int CMD_DEPTH = 2;
   localparam int PTR_W     = $clog2(CMD_DEPTH);
   localparam int FILL_CW   = $clog2(CMD_DEPTH + 1);

   cmd_type              slots_ff [CMD_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FILL_CW-1:0]   fill_ff, fill_in;
   logic                 push;
   cmd_type              new_cmd;

   // classify the incoming word
   always_comb begin
      new_cmd.is_tick   = (req_word.func == FUNC_TICK);
      new_cmd.data_byte = req_word.data_byte;
   end

   assign req_stall = (fill_ff == FILL_CW'(CMD_DEPTH));
   assign push      = req_valid & ~req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = slots_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !cmd_pop) begin
         fill_in = fill_ff + FILL_CW'(1);
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - FILL_CW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // command slots
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- hdl/utq_back.sv -----
// back end: byte queue, frame sequencer and result register
module utq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  utq_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output utq_pkg::rsp_word_type rsp_word
);
   import utq_pkg::*;

   localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int BITS_W    = 4;
   localparam int DATA_BITS = 8;

   // frame phase codes
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_PARITY = 3'd3;
   localparam logic [2:0] PH_STOP   = 3'd4;

   logic [BYTE_W-1:0] byte_mem [QUEUE_DEPTH];

   logic              parity_enable_ff;
   logic [2:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] shift_byte_ff, shift_byte_in;
   logic [BITS_W-1:0] bits_left_ff, bits_left_in;
   logic              parity_acc_ff, parity_acc_in;
   logic              line_ff, line_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              exec;
   logic              dropped;
   logic              mem_wr;
   logic              load_shift;
   logic              shift_en;
   logic              next_phase_data_done;
   logic [2:0]        leave_data_phase;

   // config register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         parity_enable_ff <= csr_data;
      end
   end

   // take a command when the result register is free or draining
   assign exec    = cmd_valid & (~rsp_valid_ff | ~rsp_stall);
   assign cmd_pop = exec;

   assign leave_data_phase     = parity_enable_ff ? PH_PARITY : PH_STOP;
   assign next_phase_data_done = (bits_left_ff == BITS_W'(1));
   assign shift_byte_in        = {1'b0, shift_byte_ff[BYTE_W-1:1]};

   // queue and frame sequencer next state
   always_comb begin
      phase_in      = phase_ff;
      bits_left_in  = bits_left_ff;
      parity_acc_in = parity_acc_ff;
      line_in       = line_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      dropped       = 1'b0;
      mem_wr        = 1'b0;
      load_shift    = 1'b0;
      shift_en      = 1'b0;
      if (exec) begin
         if (!cmd.is_tick) begin
            // push a byte
            if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
               mem_wr   = 1'b1;
               tail_in  = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + IDX_W'(1);
               count_in = count_ff + CNT_W'(1);
            end else begin
               dropped = 1'b1;
            end
         end else begin
            // one bit time
            unique case (phase_ff)
               PH_START: begin
                  if (count_ff != '0) begin
                     load_shift    = 1'b1;
                     head_in       = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : head_ff + IDX_W'(1);
                     count_in      = count_ff - CNT_W'(1);
                     bits_left_in  = BITS_W'(DATA_BITS);
                     parity_acc_in = 1'b0;
                     line_in       = 1'b0;
                     phase_in      = PH_DATA;
                  end else begin
                     line_in = 1'b1;
                  end
               end
               PH_DATA: begin
                  if (bits_left_ff != '0) begin
                     line_in       = shift_byte_ff[0];
                     shift_en      = 1'b1;
                     parity_acc_in = parity_acc_ff ^ shift_byte_ff[0];
                     bits_left_in  = bits_left_ff - BITS_W'(1);
                     if (next_phase_data_done) begin
                        phase_in = leave_data_phase;
                     end
                  end else begin
                     line_in  = 1'b1;
                     phase_in = leave_data_phase;
                  end
               end
               PH_PARITY: begin
                  line_in  = parity_acc_ff;
                  phase_in = PH_STOP;
               end
               PH_STOP: begin
                  line_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
               default: begin
                  line_in  = 1'b1;
                  phase_in = (count_ff != '0) ? PH_START : PH_IDLE;
               end
            endcase
         end
      end
   end

   // result register next state
   always_comb begin
      rsp_valid_in = exec | (rsp_valid_ff & rsp_stall);
      rsp_word_in  = rsp_word_ff;
      if (exec) begin
         rsp_word_in.line_level   = line_in;
         rsp_word_in.queue_fill   = FILL_W'(count_in);
         rsp_word_in.push_dropped = dropped;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bits_left_ff  <= '0;
         parity_acc_ff <= 1'b0;
         line_ff       <= 1'b1;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bits_left_ff  <= bits_left_in;
         parity_acc_ff <= parity_acc_in;
         line_ff       <= line_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // byte memory with registered read into the shift register
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         byte_mem[tail_ff] <= cmd.data_byte;
      end
      if (load_shift) begin
         shift_byte_ff <= byte_mem[head_ff];
      end else if (shift_en) begin
         shift_byte_ff <= shift_byte_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("byte queue count above depth");

   // empty or full queue has head and tail together
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(QUEUE_DEPTH)) |-> (head_ff == tail_ff))
      else $error("queue pointers disagree with count");

   // a start bit with a waiting byte enters data with a full bit count
   a_start_load: assert property (@(posedge clock) disable iff (reset)
      (exec && cmd.is_tick && phase_ff == PH_START && count_ff != '0) |=>
      (phase_ff == PH_DATA && bits_left_ff == BITS_W'(DATA_BITS) && !line_ff))
      else $error("start bit did not load a frame");

endmodule

// ----- hdl/uart_transmitter_with_queue_top.sv -----
// top level of the uart transmitter with byte queue
//
//   channel  handshake             payload        direction
//   req      req_valid/req_stall   req_word       in  (push byte or bit tick)
//   rsp      rsp_valid/rsp_stall   rsp_word       out (line, fill, drop flag)
//   csr      csr_valid/csr_ready   csr_data       in  (parity enable)
//
// one word per clock sustained while rsp is not stalled; an accepted word goes to a
// command queue slot, then through the sequencer into the result register.
// a two-entry command queue lets req keep flowing for up to two words while rsp is stalled.
// synchronous active-high reset; no clearing pass, the byte store is not initialized.
module uart_transmitter_with_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  utq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output utq_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);
   import utq_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // accept and classify
   utq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // queue, framer and result
   utq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
